>>> hdl/vshs_pkg.sv
// Shared types, codes and constants for the video sequence header splitter.
`timescale 1ns / 1ps
`default_nettype none

package vshs_pkg;

    // Default saturation point of the packet byte counter.
    localparam int MAX_PACKET_BYTES_DEF = 65535;

    // Configuration port layout.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_CODEC_MODE    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REMOVE_HEADER = 1'd1;

    // Codec rule selection.
    localparam logic CODEC_MPEG12 = 1'b0;
    localparam logic CODEC_MPEG4  = 1'b1;

    // Start codes as seen in the 32-bit window.
    localparam logic [23:0] START_PREFIX     = 24'h000001;
    localparam logic [31:0] START_SEQ_HEADER = 32'h000001B3;
    localparam logic [31:0] START_EXTENSION  = 32'h000001B5;
    localparam logic [31:0] START_VOP        = 32'h000001B6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        header_found;
        logic [15:0] header_length;
        logic [15:0] body_offset;
        logic [15:0] body_length;
    } out_item_t;

endpackage

`default_nettype wire

>>> hdl/video_sequence_header_splitter_unit.sv
// Top level of the video sequence header splitter: handshakes, settings, result register.
`timescale 1ns / 1ps
`default_nettype none

// The block scans the bytes of one video packet for MPEG start codes and, on
// the packet's last byte, reports where the sequence header prefix ends.
// Bytes arrive as requests on the in channel (in_valid, in_ready, in_data);
// in_data.last_byte closes a packet. Exactly one result request leaves on the
// out channel (out_valid, out_ready, out_data) per packet, carrying the header
// flag, the header length and the body offset and length.
// An accepted byte is held in the input register, is judged against the 32-bit
// start-code window, and on a last byte the result is registered in the
// output register. One byte per cycle is sustained while no last byte waits
// behind a held result, limited by the single window compare and counter
// update done per byte.
// When the receiver stalls, the held result keeps its place and bytes of the
// following packet keep flowing; only a second last byte waits in the input
// register until the held result has been taken.
// Settings are written through cfg_we, cfg_addr and cfg_wdata while no packet
// is in flight; the user must keep to it, the block does not enforce it. Reset clears
// both settings, the packet state and all valid flags; the window returns to all ones.

module video_sequence_header_splitter_unit #(
    parameter int MAX_PACKET_BYTES = vshs_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output      logic                              in_ready,
    input  wire vshs_pkg::in_item_t                in_data,
    output      logic                              out_valid,
    input  wire logic                              out_ready,
    output      vshs_pkg::out_item_t               out_data,
    input  wire logic                              cfg_we,
    input  wire logic [vshs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [vshs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import vshs_pkg::*;

    logic      codec_mode_reg;
    logic      remove_header_reg;

    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      s1_adv;

    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t scan_result;

    // The staged byte moves on unless it closes a packet and the result
    // register still holds an untaken result.
    assign s1_adv   = s1_valid_reg &&
                      (!s1_item_reg.last_byte || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    // Settings registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_mode_reg    <= CODEC_MPEG12;
            remove_header_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_CODEC_MODE:    codec_mode_reg    <= cfg_wdata[0];
                CFG_REMOVE_HEADER: remove_header_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Valid flags of the input stage and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv && s1_item_reg.last_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_data;
        end
        if (s1_adv && s1_item_reg.last_byte)
        begin
            out_data_reg <= scan_result;
        end
    end

    vshs_scanner #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_scanner (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_adv),
        .item         (s1_item_reg),
        .codec_mode   (codec_mode_reg),
        .remove_header(remove_header_reg),
        .result       (scan_result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // An empty input stage always takes a new byte.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stage empty but not ready");

    // The header flag agrees with a nonzero header length.
    a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.header_found == (out_data.header_length != 16'd0)))
        else $error("header flag and length disagree");

    // The body never starts beyond the end of the header.
    a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.body_offset <= out_data.header_length))
        else $error("body offset beyond header length");

    // A last byte stalls in the input stage only behind a held result.
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> (out_valid_reg && !out_ready))
        else $error("input stage stalled without a held result");

endmodule

`default_nettype wire

>>> hdl/vshs_scanner.sv
// Start code scanner: per-packet search state and end-of-packet result logic.
`timescale 1ns / 1ps
`default_nettype none

module vshs_scanner #(
    parameter int MAX_PACKET_BYTES = vshs_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire vshs_pkg::in_item_t  item,
    input  wire logic                codec_mode,
    input  wire logic                remove_header,
    output vshs_pkg::out_item_t      result
);
    import vshs_pkg::*;

    localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int LW = (PW > 17) ? PW : 17;

    logic [31:0]   win_reg, win_next;
    logic          seq_reg, seq_next;
    logic          dec_reg, dec_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] lat_reg, lat_next;
    logic [PW-1:0] offset;
    logic [PW-1:0] body;
    logic          is_code;

    // Clamp a counter-wide value to the 16-bit result fields.
    function automatic logic [15:0] sat16(input logic [PW-1:0] v);
        logic [LW-1:0] wide;
        wide = LW'(v);
        if (wide > LW'(16'hFFFF)) begin
            return 16'hFFFF;
        end
        return wide[15:0];
    endfunction

    always_comb
    begin
        win_next = {win_reg[23:0], item.data_byte};
        is_code  = (win_next[31:8] == START_PREFIX);
        seq_next = seq_reg;
        dec_next = dec_reg;
        lat_next = lat_reg;
        if (!dec_reg)
        begin
            if (codec_mode == CODEC_MPEG12)
            begin
                if (win_next == START_SEQ_HEADER)
                begin
                    seq_next = 1'b1;
                end
                else if (seq_reg && is_code && (win_next != START_EXTENSION)
                         && (pos_reg >= PW'(3)))
                begin
                    lat_next = pos_reg - PW'(3);
                    dec_next = 1'b1;
                end
            end
            else if ((win_next == START_SEQ_HEADER) || (win_next == START_VOP))
            begin
                if (pos_reg >= PW'(4))
                begin
                    lat_next = pos_reg - PW'(3);
                end
                dec_next = 1'b1;
            end
        end

        pos_next = (pos_reg < PW'(MAX_PACKET_BYTES)) ? pos_reg + PW'(1) : pos_reg;

        offset = (remove_header && (lat_next != '0)) ? lat_next : '0;
        if (offset > pos_next)
        begin
            offset = pos_next;
        end
        body = pos_next - offset;

        result.header_found  = (lat_next != '0);
        result.header_length = sat16(lat_next);
        result.body_offset   = sat16(offset);
        result.body_length   = sat16(body);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '1;
            seq_reg <= 1'b0;
            dec_reg <= 1'b0;
            pos_reg <= '0;
            lat_reg <= '0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                win_reg <= '1;
                seq_reg <= 1'b0;
                dec_reg <= 1'b0;
                pos_reg <= '0;
                lat_reg <= '0;
            end
            else
            begin
                win_reg <= win_next;
                seq_reg <= seq_next;
                dec_reg <= dec_next;
                pos_reg <= pos_next;
                lat_reg <= lat_next;
            end
        end
    end

    // A latched header length only exists once the search has been settled.
    a_len_implies_decided: assert property (@(posedge clk) disable iff (!rst_n)
        (lat_reg != '0) |-> dec_reg)
        else $error("header length latched without a decision");

    // The last byte of a packet leaves the counter ready for a new packet.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.last_byte) |=> (pos_reg == '0) && (win_reg == '1))
        else $error("packet state not cleared after last byte");

    // The byte counter never runs past its saturation point.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(MAX_PACKET_BYTES))
        else $error("byte position beyond maximum");

endmodule

`default_nettype wire
